### rtl/core/dfma_pkg.sv
// dfma_pkg: shared constants, types and helpers for the friction block assembly.
// No dependencies.
`default_nettype none
package dfma_pkg;
  localparam int unsigned NUM_PARTICLES = 1024;
  localparam int unsigned DIMS          = 3;
  localparam int unsigned BLK           = DIMS * DIMS;
  localparam int unsigned PW            = 10;
  localparam int unsigned MEM_DEPTH     = NUM_PARTICLES * BLK;
  localparam int unsigned AW            = $clog2(MEM_DEPTH);
  localparam int unsigned EW            = $clog2(BLK + 1);
  localparam int unsigned CW            = 12;

  localparam logic [0:0] OP_PAIR  = 1'b0;
  localparam logic [0:0] OP_FLUSH = 1'b1;

  localparam logic [0:0] REG_CUTOFF = 1'b0;
  localparam logic [0:0] REG_GAIN   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WDIV, ST_ENT_A, ST_ENT_B, ST_ENT_C, ST_ENT_D,
    ST_RD, ST_WB, ST_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [23:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] r;
    r = {a[31], a} - {b[31], b};
    if (r > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (r < -33'sh0_8000_0000) return 32'sh8000_0000;
    return r[31:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/dfma_if.sv
// dfma_if: valid/ready channel with a generic payload type.
// Depends on nothing.
`default_nettype none
interface dfma_if #(parameter type T = logic) (input wire logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/dfma_ram.sv
// dfma_ram: single port synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module dfma_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### rtl/core/dfma_div.sv
// dfma_div: radix-2 restoring divider, 64 by 24 bit, one quotient bit a cycle.
// Depends on dfma_pkg.
`default_nettype none
module dfma_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dfma_pkg::div_req_t req_i,
  output dfma_pkg::div_rsp_t      rsp_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d;
  logic [23:0] den_q, den_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [24:0] sh;

  always_comb begin
    cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    busy_d = busy_q; done_d = 1'b0;
    sh = {rem_q[23:0], quo_q[63]};
    if (req_i.start) begin
      quo_d = req_i.num; den_d = req_i.den; rem_d = '0;
      cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

### rtl/core/dpd_friction_matrix_assembly.sv
// dpd_friction_matrix_assembly: top level, sequencer around the diagonal RAM
// and a shared serial divider. Depends on dfma_pkg, dfma_if, dfma_ram, dfma_div.
//
// channel | dir | payload
// in_ch   | in  | op, first/second particle, distance, rel x/y/z
// out_ch  | out | matrix row/column, entry value, last flag
// cfg_ch  | in  | register index (1 bit), 24 bit data
//
// Steps: a pair is accepted and, below the cutoff, its weight is divided out;
// then each of the nine entries takes up to two divisions (issue plus wait)
// and a RAM read, write and output step; with a zero weight it skips both.
// A flush reads, clears and outputs each nonzero block entry in turn.
// Reset: a clearing pass zeroes all 9216 RAM words, one per cycle; no item
// is accepted until it ends. Configuration writes are always taken.
// Stalls: the output register holds its item until taken; the sequencer waits.
// A new item waits until the last held flush entry has moved to the output.
`default_nettype none
module dpd_friction_matrix_assembly (
  input wire logic clk_i,
  input wire logic rst_ni,
  dfma_if.sink     in_ch,
  dfma_if.source   out_ch,
  dfma_if.sink     cfg_ch
);
  localparam int unsigned AW = dfma_pkg::AW;
  localparam int unsigned EW = dfma_pkg::EW;
  localparam int unsigned CW = dfma_pkg::CW;

  dfma_pkg::state_e state_q, state_d;

  logic [23:0] cutoff_q, gain_q;
  // latched item
  logic        op_q;
  logic [dfma_pkg::PW-1:0] p1_q, p2_q;
  logic [23:0] dist_q;
  logic signed [23:0] rel_q [dfma_pkg::DIMS];
  logic [47:0] w_q;      // weight (<= gain)
  logic [63:0] t_q;
  logic [EW-1:0] ent_q, ent_d;
  logic [1:0]  ra_q, rb_q, ra_d, rb_d;
  logic signed [31:0] val_q, val_d;
  logic [AW-1:0] clr_q;
  logic        ld_item;

  // output register
  logic        ov_q;
  logic [CW-1:0] orow_q, ocol_q;
  logic signed [31:0] oval_q;
  logic        olast_q;
  logic        pend_q;   // flush entry held back for the last flag

  // RAM
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  logic [AW-1:0] base;

  dfma_pkg::div_req_t dreq;
  dfma_pkg::div_rsp_t drsp;

  dfma_ram #(.WIDTH(32), .DEPTH(dfma_pkg::MEM_DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata));
  dfma_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= 24'd65536; gain_q <= 24'd65536;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == dfma_pkg::REG_CUTOFF) cutoff_q <= cfg_ch.data.value;
      else gain_q <= cfg_ch.data.value;
    end
  end

  // entry operands
  logic signed [23:0] av, bv;
  logic [23:0] ma, mb;
  logic [47:0] mprod;
  logic        neg;
  assign av = rel_q[ra_q];
  assign bv = rel_q[rb_q];
  assign ma = av[23] ? 24'(-av) : 24'(av);
  assign mb = bv[23] ? 24'(-bv) : 24'(bv);
  assign mprod = ma * mb;
  assign neg = av[23] ^ bv[23];

  assign base = AW'(p1_q * dfma_pkg::BLK);

  logic in_ok;
  assign in_ok = (in_ch.data.first_particle < dfma_pkg::NUM_PARTICLES) &&
                 ((in_ch.data.op == dfma_pkg::OP_FLUSH) ||
                  ((in_ch.data.second_particle < dfma_pkg::NUM_PARTICLES) &&
                   (in_ch.data.pair_distance != 24'd0)));

  assign in_ch.ready = (state_q == dfma_pkg::ST_IDLE) && !pend_q;
  assign ld_item = in_ch.valid && in_ch.ready && in_ok;

  // W*t product; t below 2^40 and W below 2^24
  logic [63:0] tw;
  assign tw = t_q[39:0] * w_q[23:0];

  logic [31:0] magsat;
  always_comb begin
    // drsp.quo holds mag here
    if (drsp.quo > 64'h8000_0000) magsat = 32'h8000_0000;
    else magsat = drsp.quo[31:0];
  end

  always_comb begin
    state_d = state_q; ent_d = ent_q; ra_d = ra_q; rb_d = rb_q; val_d = val_q;
    dreq = '0; we = 1'b0; addr = base + AW'(ent_q); wdata = '0;
    unique case (state_q)
      dfma_pkg::ST_CLEAR: begin
        we = 1'b1; addr = clr_q;
        if (clr_q == AW'(dfma_pkg::MEM_DEPTH - 1)) state_d = dfma_pkg::ST_IDLE;
      end
      dfma_pkg::ST_IDLE: begin
        ent_d = '0; ra_d = '0; rb_d = '0;
        if (ld_item) begin
          if (in_ch.data.op == dfma_pkg::OP_FLUSH) state_d = dfma_pkg::ST_RD;
          else if (in_ch.data.pair_distance >= cutoff_q) begin
            state_d = dfma_pkg::ST_ENT_A;
          end else begin
            dreq.start = 1'b1;
            dreq.num = {16'd0, 48'(gain_q) * 48'(cutoff_q - in_ch.data.pair_distance)};
            dreq.den = cutoff_q;
            state_d = dfma_pkg::ST_WDIV;
          end
        end
      end
      dfma_pkg::ST_WDIV: if (drsp.done) state_d = dfma_pkg::ST_ENT_A;
      dfma_pkg::ST_ENT_A: begin
        if (w_q == '0) begin
          val_d = '0; state_d = dfma_pkg::ST_RD;
        end else begin
          dreq.start = 1'b1; dreq.num = 64'(mprod); dreq.den = dist_q;
          state_d = dfma_pkg::ST_ENT_B;
        end
      end
      dfma_pkg::ST_ENT_B: if (drsp.done) state_d = dfma_pkg::ST_ENT_C;
      dfma_pkg::ST_ENT_C: begin
        if (t_q == '0) begin
          val_d = '0; state_d = dfma_pkg::ST_RD;
        end else if (t_q >= 64'h100_0000_0000) begin
          val_d = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF; state_d = dfma_pkg::ST_RD;
        end else begin
          dreq.start = 1'b1; dreq.num = tw; dreq.den = dist_q;
          state_d = dfma_pkg::ST_ENT_D;
        end
      end
      dfma_pkg::ST_ENT_D: if (drsp.done) begin
        if (neg) val_d = -$signed(magsat);
        else val_d = magsat[31] ? 32'sh7FFF_FFFF : $signed(magsat);
        state_d = dfma_pkg::ST_RD;
      end
      dfma_pkg::ST_RD: state_d = dfma_pkg::ST_WB;   // RAM read issued
      dfma_pkg::ST_WB: begin
        we = 1'b1;
        if (op_q == dfma_pkg::OP_FLUSH) begin
          wdata = '0; val_d = $signed(rdata);
        end else wdata = dfma_pkg::sat_sub($signed(rdata), val_q);
        state_d = dfma_pkg::ST_OUT;
      end
      dfma_pkg::ST_OUT: begin
        if (!ov_q || out_ch.ready) begin
          if (ent_q == EW'(dfma_pkg::BLK - 1)) state_d = dfma_pkg::ST_IDLE;
          else begin
            ent_d = ent_q + EW'(1);
            if (rb_q == 2'(dfma_pkg::DIMS - 1)) begin
              rb_d = '0; ra_d = ra_q + 2'd1;
            end else rb_d = rb_q + 2'd1;
            state_d = (op_q == dfma_pkg::OP_FLUSH) ? dfma_pkg::ST_RD
                                                  : dfma_pkg::ST_ENT_A;
          end
        end
      end
      default: state_d = dfma_pkg::ST_IDLE;
    endcase
  end

  // a flush emits only nonzero words; last flag looks ahead via remaining nonzero
  // words, so flush emissions are held one step in a pending register.
  logic [CW-1:0] prow_q, pcol_q;
  logic signed [31:0] pval_q;
  logic        out_go;
  assign out_go = (state_q == dfma_pkg::ST_OUT) && (!ov_q || out_ch.ready);
  logic        is_last;
  assign is_last = (ent_q == EW'(dfma_pkg::BLK - 1));
  logic [CW-1:0] rrow, rcol;
  assign rrow = CW'(p1_q * dfma_pkg::DIMS + ra_q);
  assign rcol = CW'(((op_q == dfma_pkg::OP_FLUSH) ? p1_q : p2_q) * dfma_pkg::DIMS + rb_q);

  // drain_go: final pending flush word moves out in idle
  logic        drain_go, ld_out;
  assign drain_go = (state_q == dfma_pkg::ST_IDLE) && pend_q && (!ov_q || out_ch.ready);
  assign ld_out   = drain_go ||
                    (out_go && ((op_q == dfma_pkg::OP_PAIR) ||
                                (pend_q && (val_q != 0 || is_last))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dfma_pkg::ST_CLEAR; clr_q <= '0; ov_q <= 1'b0; pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dfma_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (ld_out) ov_q <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ov_q <= 1'b0;
      if (drain_go) pend_q <= 1'b0;
      else if (out_go && (op_q == dfma_pkg::OP_FLUSH)) begin
        if (val_q != 0) pend_q <= 1'b1;
        else if (is_last) pend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d; ra_q <= ra_d; rb_q <= rb_d; val_q <= val_d;
    if (ld_item) begin
      op_q <= in_ch.data.op; p1_q <= in_ch.data.first_particle;
      p2_q <= in_ch.data.second_particle; dist_q <= in_ch.data.pair_distance;
      rel_q[0] <= in_ch.data.rel_x;
      if (dfma_pkg::DIMS > 1) rel_q[1 % dfma_pkg::DIMS] <= in_ch.data.rel_y;
      if (dfma_pkg::DIMS > 2) rel_q[2 % dfma_pkg::DIMS] <= in_ch.data.rel_z;
      w_q <= '0;
    end
    if (state_q == dfma_pkg::ST_WDIV && drsp.done) w_q <= drsp.quo[47:0];
    if (state_q == dfma_pkg::ST_ENT_B && drsp.done) t_q <= drsp.quo;
    if (out_go) begin
      if (op_q == dfma_pkg::OP_PAIR) begin
        orow_q <= rrow; ocol_q <= rcol; oval_q <= val_q; olast_q <= is_last;
      end else begin
        if (pend_q && (val_q != 0 || is_last)) begin
          orow_q <= prow_q; ocol_q <= pcol_q; oval_q <= pval_q;
          olast_q <= (val_q == 0);
        end
        if (val_q != 0) begin
          prow_q <= rrow; pcol_q <= rcol; pval_q <= val_q;
        end
      end
    end
    if (drain_go) begin
      orow_q <= prow_q; ocol_q <= pcol_q; oval_q <= pval_q; olast_q <= 1'b1;
    end
  end

  assign out_ch.valid              = ov_q;
  assign out_ch.data.matrix_row    = orow_q;
  assign out_ch.data.matrix_column = ocol_q;
  assign out_ch.data.entry_value   = oval_q;
  assign out_ch.data.last_entry    = olast_q;

`ifndef SYNTHESIS
  a_no_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfma_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("input taken during clearing pass");
  a_wb_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dfma_pkg::ST_WB) |-> $past(state_q) == dfma_pkg::ST_RD)
    else $error("write-back without read");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
`endif
endmodule
`default_nettype wire

### tb/sv/dfma_tb_pkg.sv
// dfma_tb_pkg: item layouts for the three channels of the friction block assembly.
// Depends on dfma_pkg for widths.
package dfma_tb_pkg;
  import dfma_pkg::*;

  typedef struct packed {
    logic [0:0]         op;
    logic [PW-1:0]      first_particle;
    logic [PW-1:0]      second_particle;
    logic [23:0]        pair_distance;
    logic signed [23:0] rel_x;
    logic signed [23:0] rel_y;
    logic signed [23:0] rel_z;
  } pair_item_t;

  typedef struct packed {
    logic [CW-1:0]      matrix_row;
    logic [CW-1:0]      matrix_column;
    logic signed [31:0] entry_value;
    logic               last_entry;
  } entry_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [23:0] value;
  } cfg_item_t;
endpackage

### tb/sv/dfma_checker.sv
// dfma_checker: watches the pair, entry and register channels, predicts the entries
// and compares them. Depends on dfma_pkg, dfma_tb_pkg and dfma_if.
module dfma_checker
  import dfma_pkg::*;
  import dfma_tb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dfma_if           in_ch,
  dfma_if           out_ch,
  dfma_if           cfg_ch,
  output int        pending_o,
  output int        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0]        cutoff_q;
  logic [23:0]        gain_q;
  logic signed [31:0] diag_acc [MEM_DEPTH];
  entry_item_t        entry_q [$];
  int                 fails;

  assign pending_o    = entry_q.size();
  assign fail_count_o = fails;

  function automatic longint unsigned weight_q16(longint unsigned d);
    longint unsigned c;
    c = cutoff_q;
    if (d >= c) return 0;
    return (longint'(gain_q) * (c - d)) / c;
  endfunction

  function automatic logic signed [31:0] block_val(longint unsigned w,
                                                   logic signed [23:0] ra,
                                                   logic signed [23:0] rb,
                                                   longint unsigned d);
    longint sa, sb;
    longint unsigned ma, mb, t, mag;
    sa = ra;
    sb = rb;
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    t = (ma * mb) / d;
    if (w == 0 || t == 0) return 0;
    mag = (t >= (64'd1 << 40)) ? 64'h8000_0000 : (t * w) / d;
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    if ((sa < 0) != (sb < 0)) return -mag;  // wraps to the most negative value at 2^31
    if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(logic signed [31:0] acc,
                                                 logic signed [31:0] v);
    longint r;
    r = longint'(acc) - longint'(v);
    if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (r < -64'sh8000_0000) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  task automatic assemble_block(pair_item_t it);
    logic signed [23:0] rel [3];
    longint unsigned    w, d;
    int                 base, n, k;
    entry_item_t        e;
    rel[0] = it.rel_x;
    rel[1] = it.rel_y;
    rel[2] = it.rel_z;
    d = it.pair_distance;
    base = int'(it.first_particle) * BLK;
    n = entry_q.size();
    if (it.op == OP_FLUSH) begin
      for (int a = 0; a < DIMS; a++) begin
        for (int b = 0; b < DIMS; b++) begin
          k = base + DIMS * a + b;
          if (diag_acc[k] != 0) begin
            e.matrix_row    = CW'(it.first_particle * DIMS + a);
            e.matrix_column = CW'(it.first_particle * DIMS + b);
            e.entry_value   = diag_acc[k];
            e.last_entry    = 1'b0;
            entry_q.push_back(e);
          end
          diag_acc[k] = '0;
        end
      end
    end else if (d != 0) begin
      w = weight_q16(d);
      for (int a = 0; a < DIMS; a++) begin
        for (int b = 0; b < DIMS; b++) begin
          k = base + DIMS * a + b;
          e.matrix_row    = CW'(it.first_particle * DIMS + a);
          e.matrix_column = CW'(it.second_particle * DIMS + b);
          e.entry_value   = block_val(w, rel[a], rel[b], d);
          e.last_entry    = 1'b0;
          entry_q.push_back(e);
          diag_acc[k] = sub_sat(diag_acc[k], e.entry_value);
        end
      end
    end
    if (entry_q.size() > n) entry_q[$].last_entry = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_item_t want, got;
    if (!rst_ni) begin
      cutoff_q <= 24'd65536;
      gain_q   <= 24'd65536;
      fails    <= 0;
      for (int i = 0; i < MEM_DEPTH; i++) diag_acc[i] = '0;
      entry_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data.index == REG_CUTOFF) cutoff_q <= cfg_ch.data.value;
        else gain_q <= cfg_ch.data.value;
      end
      if (in_ch.valid && in_ch.ready) assemble_block(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (entry_q.size() == 0) begin
          if (fails < 10) $display("unexpected entry: row %0d col %0d val %0d last %0b",
                                   got.matrix_row, got.matrix_column, got.entry_value,
                                   got.last_entry);
          fails <= fails + 1;
        end else begin
          want = entry_q.pop_front();
          if (got !== want) begin
            if (fails < 10) $display({"entry mismatch: exp row %0d col %0d val %0d last %0b,",
                                      " got row %0d col %0d val %0d last %0b"},
                                     want.matrix_row, want.matrix_column, want.entry_value,
                                     want.last_entry, got.matrix_row, got.matrix_column,
                                     got.entry_value, got.last_entry);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/testbench.sv
// testbench: stimulus and verdict for dpd_friction_matrix_assembly.
// Depends on dfma_pkg, dfma_tb_pkg, dfma_if, dfma_checker and the RTL top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfma_pkg::*;
  import dfma_tb_pkg::*;

  // Each pair runs its divisions through the serial divider; about 450 items plus
  // the clearing pass and the stalls stay far below this.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 1400;  // longer than one pair, covers zero-distance items
  localparam int HOLD_CYCLES = 6000;  // long enough for the block to back up into in_ch

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  dfma_if #(.T(pair_item_t))  in_ch  (clk_i);
  dfma_if #(.T(entry_item_t)) out_ch (clk_i);
  dfma_if #(.T(cfg_item_t))   cfg_ch (clk_i);

  dpd_friction_matrix_assembly u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  int pending, fail_count;

  dfma_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  int   in_idle_pct = 35;
  int   out_idle_pct = 61;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int   cycles = 0;

  // receiver: random back-pressure, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[dpd_friction_matrix_assembly] ERROR");
      $finish;
    end
  end

  task automatic send_item(pair_item_t it);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // valid is lowered after each write, which keeps back-to-back writes apart
  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.data.index  <= idx;
    cfg_ch.data.value  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // lower valid, wait for every entry, then let a trailing zero-distance item finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic pair_item_t mk(logic [0:0] op, int p1, int p2, int d,
                                    int x, int y, int z);
    pair_item_t it;
    it.op = op;
    it.first_particle = PW'(p1);
    it.second_particle = PW'(p2);
    it.pair_distance = 24'(d);
    it.rel_x = 24'(x);
    it.rel_y = 24'(y);
    it.rel_z = 24'(z);
    return it;
  endfunction

  // Mostly pairs on a few particles with distances near the cutoff so the
  // weights are nonzero and the diagonals build up; some full-range noise.
  function automatic pair_item_t rand_item(int cut);
    pair_item_t it;
    int         span;
    it = pair_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    if ($urandom_range(0, 99) < 15) begin
      it.op = OP_FLUSH;
      it.first_particle = PW'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 5));
      return it;
    end
    if ($urandom_range(0, 99) < 85) begin
      it.op = OP_PAIR;
      it.first_particle = PW'($urandom_range(0, 5));
      it.second_particle = PW'($urandom_range(0, 19) == 0 ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, 5));
      span = (cut > 24'h7FFFFF) ? 24'h7FFFFF : cut + cut / 4 + 1;
      it.pair_distance = 24'($urandom_range(1, span));
      it.rel_x = 24'($signed(24'($urandom_range(0, span))) *
                     ($urandom_range(0, 1) ? 1 : -1));
      it.rel_y = 24'($signed(24'($urandom_range(0, span))) *
                     ($urandom_range(0, 1) ? 1 : -1));
      it.rel_z = 24'($signed(24'($urandom_range(0, span))) *
                     ($urandom_range(0, 1) ? 1 : -1));
    end
    return it;
  endfunction

  task automatic run_phase(int n, int cut);
    for (int i = 0; i < n; i++) send_item(rand_item(cut));
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset registers (cutoff 1.0, gain 1.0)
    send_item(mk(OP_PAIR, 1, 2, 0, 100, 200, 300));                  // zero distance
    send_item(mk(OP_PAIR, 1, 2, 32'h10000, 5000, 6000, 7000));       // at cutoff: zeros
    send_item(mk(OP_PAIR, 1, 2, 32'hFFFFFF, 24'h7FFFFF, 1, -1));     // beyond cutoff
    send_item(mk(OP_PAIR, 1, 2, 32'h8000, 32'h8000, -32'h8000, 32'h4000));
    send_item(mk(OP_PAIR, 1, 2, 1, 24'h7FFFFF, -24'h800000, 24'h7FFFFF)); // saturation
    send_item(mk(OP_PAIR, 1, 3, 1, -24'h800000, -24'h800000, 0));
    send_item(mk(OP_FLUSH, 1, 0, 0, 0, 0, 0));
    send_item(mk(OP_FLUSH, 1, 0, 0, 0, 0, 0));                       // empty flush
    send_item(mk(OP_PAIR, 1023, 1023, 32'h4000, 32'h1000, -32'h2000, 32'h3000));
    send_item(mk(OP_PAIR, 0, 1023, 32'h100, 32'h80, 32'h80, -32'h80));
    send_item(mk(OP_PAIR, 0, 0, 1, 1, 1, 1));                        // tiny values
    send_item(mk(OP_FLUSH, 1023, 0, 0, 0, 0, 0));
    send_item(mk(OP_FLUSH, 0, 1023, 24'hFFFFFF, -1, -1, -1));
    send_item(mk(OP_FLUSH, 512, 0, 0, 0, 0, 0));
    drain();

    // full-scale registers; the receiver holds off a long stretch here
    write_reg(REG_CUTOFF, 24'hFFFFFF);
    write_reg(REG_GAIN, 24'hFFFFFF);
    hold_go <= 1'b1;
    send_item(mk(OP_PAIR, 4, 5, 1, 24'h7FFFFF, 24'h7FFFFF, -24'h800000));
    send_item(mk(OP_PAIR, 4, 5, 1, 24'h7FFFFF, 24'h7FFFFF, -24'h800000));
    send_item(mk(OP_FLUSH, 4, 0, 0, 0, 0, 0));
    run_phase(100, 24'hFFFFFF);
    drain();  // sender waits for every entry

    // cutoff 1, zero gain: all weights zero
    write_reg(REG_CUTOFF, 24'd1);
    write_reg(REG_GAIN, 24'd0);
    run_phase(40, 1);
    drain();

    in_idle_pct = 61;
    out_idle_pct = 35;
    write_reg(REG_CUTOFF, 24'h20000);
    write_reg(REG_GAIN, 24'h18000);
    run_phase(150, 24'h20000);
    drain();

    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(REG_CUTOFF, 24'($urandom_range(24'h8000, 24'h80000)));
    write_reg(REG_GAIN, 24'($urandom_range(0, 24'hFFFFFF)));
    run_phase(70, 24'h80000);
    drain();
    write_reg(REG_CUTOFF, 24'h10000);
    write_reg(REG_GAIN, 24'h10000);
    run_phase(70, 24'h10000);
    drain();

    if (fail_count == 0) begin
      $display("[dpd_friction_matrix_assembly] OK");
    end else begin
      $display("[dpd_friction_matrix_assembly] ERROR");
    end
    $finish;
  end
endmodule
